[design/hng_pkg.sv]
// Shared types and constants for the heightmap normal generator.
// Used by hng_unit, heightmap_normal_generator and the bench; no dependencies.
package hng_pkg;

    // Default line store depth
    localparam int MAX_WIDTH_DEF = 256;

    // Arithmetic widths
    localparam int MAG_W   = 23;   // |dh * range|
    localparam int MAG2_W  = 46;   // square of a magnitude
    localparam int SUM_W   = 47;   // squared length of the raw normal
    localparam int QUO_W   = 31;   // floor(2^30 * mag^2 / sum)
    localparam int ROOT_W  = 16;   // isqrt of the quotient
    localparam int UNIT_W  = 15;   // result magnitude, 0..16384

    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;

    // Raw y component is 2.0 in the common scale: 65280, squared
    localparam logic [MAG2_W-1:0] Y_MAG2 = MAG2_W'(64'd4261478400);

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RANGE  = 2'd2;

    // Component select for the shared unit
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_C,
        S_RD_L,
        S_RD_R,
        S_GET_R,
        S_MUL_X,
        S_MUL_Z,
        S_SQ_X,
        S_SQ_Z,
        S_SUM,
        S_UNIT_GO,
        S_UNIT_WAIT,
        S_OUT,
        S_UPDATE
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_PREP,
        U_SQRT,
        U_DONE
    } t_unit_state;

    // Request into the shared normalizing unit
    typedef struct packed {
        logic              start;
        logic [MAG2_W-1:0] mag2;
        logic [SUM_W-1:0]  sum;
    } t_unit_req;

    // Status back from the shared normalizing unit
    typedef struct packed {
        logic              done;
        logic [UNIT_W-1:0] mag;
    } t_unit_rsp;

endpackage

[design/hng_unit.sv]
// Shared normalizing unit: round(16384 * sqrt(mag2 / sum)) by restoring
// division followed by a digit-by-digit square root. Depends on hng_pkg.
module hng_unit import hng_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    t_unit_state r_state, n_state;
    logic [4:0]        r_cnt;
    logic [SUM_W:0]    r_rem;
    logic [SUM_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_nlo;
    logic [QUO_W-1:0]  r_quo;
    logic [31:0]       r_rad;
    logic [19:0]       r_srem;
    logic [ROOT_W-1:0] r_root;

    logic [SUM_W:0]    div_trial;
    logic              div_ge;
    logic [19:0]       sq_rem2;
    logic [19:0]       sq_trial;
    logic              sq_ge;
    logic [ROOT_W:0]   root_inc;

    // Datapath steps
    assign div_trial = {r_rem[SUM_W-1:0], r_nlo[QUO_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div};
    assign sq_rem2   = {r_srem[17:0], r_rad[31:30]};
    assign sq_trial  = {2'b00, r_root, 2'b01};
    assign sq_ge     = sq_rem2 >= sq_trial;
    assign root_inc  = {1'b0, r_root} + (ROOT_W+1)'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: if (i_req.start) n_state = U_DIV;
            U_DIV:  if (r_cnt == 5'(DIV_STEPS - 1)) n_state = U_PREP;
            U_PREP: n_state = U_SQRT;
            U_SQRT: if (r_cnt == 5'(SQRT_STEPS - 1)) n_state = U_DONE;
            U_DONE: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = (r_state == U_DONE);
        o_rsp.mag  = root_inc[UNIT_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Iteration registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                r_rem <= {3'b000, i_req.mag2[MAG2_W-1:1]};
                r_nlo <= {i_req.mag2[0], (QUO_W-1)'(0)};
                r_div <= i_req.sum;
                r_quo <= '0;
                r_cnt <= '0;
            end
            U_DIV: begin
                r_rem <= div_ge ? div_trial - {1'b0, r_div} : div_trial;
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
                r_nlo <= {r_nlo[QUO_W-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            U_PREP: begin
                r_rad  <= {1'b0, r_quo};
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            U_SQRT: begin
                r_srem <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
                r_root <= {r_root[ROOT_W-2:0], sq_ge};
                r_rad  <= {r_rad[29:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

[design/heightmap_normal_generator.sv]
// Heightmap normal generator top level: line stores, sequencer, shared
// multiplier and output register. Depends on hng_pkg and hng_unit.
//
// Samples arrive in raster order; each normal leaves one row behind its
// input, so row 0 gives no result and drain beats flush the last row. An
// item that yields a normal first goes through the check, the line store
// reads, the shared multiplier and the sum. Then come three passes through
// the normalizing unit, each with 31 division steps and 16 square root
// steps. Output and update follow, and the block returns to idle. A stalled
// result register adds its wait. Ignored beats go from the check back to
// idle, and row-0 samples go from the check straight to the update. The
// block takes no new beat until the current item has finished. Write width,
// height and range only while the block is idle; the block itself does not
// enforce this.
module heightmap_normal_generator import hng_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [7:0]         i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [7:0]         o_pixel_column,
    output logic [15:0]        o_pixel_row,
    output logic               o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration
    logic [8:0]         r_width;
    logic [15:0]        r_height;
    logic signed [15:0] r_range;

    // Frame state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_col;
    logic [15:0]     r_rows;
    logic            r_sel;
    logic            r_draining;

    // Current beat
    logic            r_op;
    logic [7:0]      r_smp;

    // Line stores
    logic [7:0]      mem_a [MAX_WIDTH];
    logic [7:0]      mem_b [MAX_WIDTH];
    logic [7:0]      r_qa, r_qb;
    logic [CW-1:0]   rd_addr;
    logic            we_a, we_b;

    // Datapath registers
    logic [7:0]          r_mid, r_up, r_left;
    logic signed [8:0]   r_dx, r_dz;
    logic [MAG_W-1:0]    r_magx, r_magz;
    logic [MAG2_W-1:0]   r_sqx, r_sqz;
    logic [SUM_W-1:0]    r_sum;
    logic [1:0]          r_comp;
    logic [UNIT_W-1:0]   r_ux, r_uy, r_uz;

    // Output register
    logic                r_ovalid;
    logic signed [15:0]  r_nx, r_ny, r_nz;
    logic [7:0]          r_ocol;
    logic [15:0]         r_orow;
    logic                r_olast;

    // Derived values
    logic [15:0]     w16, wlim;
    logic [CW-1:0]   wm1;
    logic [15:0]     hlim;
    logic [CW-1:0]   li, ri;
    logic [CW:0]     ri_w;
    logic            row_end;
    logic            ignore;
    logic [7:0]      ctr_q, oth_q;
    logic [7:0]      down;
    logic signed [8:0] dx_n, dz_n;
    logic [16:0]     hr_abs17;
    logic [15:0]     hr_abs;
    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [MAG2_W-1:0] mul_p;
    logic            out_free;
    logic [CW+7:0]   col_ext;
    t_unit_req       unit_req;
    t_unit_rsp       unit_rsp;

    // Clamp width and height to their usable ranges
    always_comb begin
        w16 = {7'b0, r_width};
        wlim = w16;
        if (w16 == 16'd0) wlim = 16'd1;
        if (w16 > 16'(MAX_WIDTH)) wlim = 16'(MAX_WIDTH);
        hlim = (r_height == 16'd0) ? 16'd1 : r_height;
    end
    assign wm1 = CW'(wlim - 16'd1);

    // Neighbor columns clamped to the row
    assign li      = (r_col == '0) ? '0 : ((r_col - CW'(1) > wm1) ? wm1 : r_col - CW'(1));
    assign ri_w    = {1'b0, r_col} + (CW+1)'(1);
    assign ri      = (ri_w > {1'b0, wm1}) ? wm1 : ri_w[CW-1:0];
    assign row_end = r_col >= wm1;
    assign ignore  = (r_op == OP_SAMPLE) == r_draining;

    assign ctr_q = r_sel ? r_qb : r_qa;
    assign oth_q = r_sel ? r_qa : r_qb;
    assign down  = r_draining ? r_mid : r_smp;
    assign dx_n  = $signed({1'b0, r_left}) - $signed({1'b0, ctr_q});
    assign dz_n  = $signed({1'b0, r_up}) - $signed({1'b0, down});

    assign hr_abs17 = r_range[15] ? 17'(-$signed({r_range[15], r_range}))
                                  : {1'b0, r_range};
    assign hr_abs   = hr_abs17[15:0];

    assign out_free = !r_ovalid || i_ready;
    assign col_ext  = {8'b0, r_col};

    // Shared multiplier
    assign mul_p = MAG2_W'(mul_a) * MAG2_W'(mul_b);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (ignore)              n_state = S_IDLE;
                else if (r_rows != 16'd0) n_state = S_RD_C;
                else                     n_state = S_UPDATE;
            end
            S_RD_C:      n_state = S_RD_L;
            S_RD_L:      n_state = S_RD_R;
            S_RD_R:      n_state = S_GET_R;
            S_GET_R:     n_state = S_MUL_X;
            S_MUL_X:     n_state = S_MUL_Z;
            S_MUL_Z:     n_state = S_SQ_X;
            S_SQ_X:      n_state = S_SQ_Z;
            S_SQ_Z:      n_state = S_SUM;
            S_SUM:       n_state = S_UNIT_GO;
            S_UNIT_GO:   n_state = S_UNIT_WAIT;
            S_UNIT_WAIT: begin
                if (unit_rsp.done) n_state = (r_comp == COMP_Z) ? S_OUT : S_UNIT_GO;
            end
            S_OUT:       if (out_free) n_state = S_UPDATE;
            S_UPDATE:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_ready  = (r_state == S_IDLE);
        rd_addr  = r_col;
        we_a     = 1'b0;
        we_b     = 1'b0;
        mul_a    = {15'b0, r_dx[8] ? 8'(-r_dx) : r_dx[7:0]};
        mul_b    = {7'b0, hr_abs};
        unit_req.start = (r_state == S_UNIT_GO);
        unit_req.sum   = r_sum;
        case (r_comp)
            COMP_X:  unit_req.mag2 = r_sqx;
            COMP_Y:  unit_req.mag2 = Y_MAG2;
            default: unit_req.mag2 = r_sqz;
        endcase
        case (r_state)
            S_RD_L: rd_addr = li;
            S_RD_R: rd_addr = ri;
            S_MUL_Z: mul_a = {15'b0, r_dz[8] ? 8'(-r_dz) : r_dz[7:0]};
            S_SQ_X: begin
                mul_a = r_magx;
                mul_b = r_magx;
            end
            S_SQ_Z: begin
                mul_a = r_magz;
                mul_b = r_magz;
            end
            S_UPDATE: begin
                we_a = !r_draining && r_sel;
                we_b = !r_draining && !r_sel;
            end
            default: rd_addr = r_col;
        endcase
    end

    // Line stores: write the newer row, registered reads
    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[r_col] <= r_smp;
        r_qa <= mem_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) mem_b[r_col] <= r_smp;
        r_qb <= mem_b[rd_addr];
    end

    hng_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_col      <= '0;
            r_rows     <= '0;
            r_sel      <= 1'b0;
            r_draining <= 1'b0;
            r_ovalid   <= 1'b0;
            r_comp     <= COMP_X;
            r_width    <= 9'd256;
            r_height   <= 16'd256;
            r_range    <= 16'sd256;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data[8:0];
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_RANGE:  r_range  <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end
            // Load a new result, or drop the held one once taken
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (r_state == S_SUM) r_comp <= COMP_X;
            if (r_state == S_UNIT_WAIT && unit_rsp.done) r_comp <= r_comp + 2'd1;
            // Advance column, row and store roles
            if (r_state == S_UPDATE) begin
                if (row_end) begin
                    r_col <= '0;
                    if (r_draining) begin
                        r_draining <= 1'b0;
                        r_rows     <= '0;
                    end else begin
                        r_rows <= r_rows + 16'd1;
                        r_sel  <= !r_sel;
                        if (r_rows + 16'd1 >= hlim) r_draining <= 1'b1;
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= i_opcode;
            r_smp <= i_sample;
        end
        if (r_state == S_RD_L) begin
            r_mid <= ctr_q;
            r_up  <= (r_rows >= 16'd2) ? oth_q : ctr_q;
        end
        if (r_state == S_RD_R) r_left <= ctr_q;
        if (r_state == S_GET_R) begin
            r_dx <= dx_n;
            r_dz <= dz_n;
        end
        if (r_state == S_MUL_X) r_magx <= mul_p[MAG_W-1:0];
        if (r_state == S_MUL_Z) r_magz <= mul_p[MAG_W-1:0];
        if (r_state == S_SQ_X)  r_sqx  <= mul_p;
        if (r_state == S_SQ_Z)  r_sqz  <= mul_p;
        if (r_state == S_SUM) begin
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqz} + {1'b0, Y_MAG2};
        end
        if (r_state == S_UNIT_WAIT && unit_rsp.done) begin
            case (r_comp)
                COMP_X:  r_ux <= unit_rsp.mag;
                COMP_Y:  r_uy <= unit_rsp.mag;
                default: r_uz <= unit_rsp.mag;
            endcase
        end
        // Load the output register; sign follows the raw component
        if (r_state == S_OUT && out_free) begin
            r_nx <= (r_dx[8] ^ r_range[15]) ? -$signed({1'b0, r_ux}) : $signed({1'b0, r_ux});
            r_ny <= $signed({1'b0, r_uy});
            r_nz <= (r_dz[8] ^ r_range[15]) ? -$signed({1'b0, r_uz}) : $signed({1'b0, r_uz});
            r_ocol  <= col_ext[7:0];
            r_orow  <= r_rows - 16'd1;
            r_olast <= r_draining && row_end;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_normal_x     = r_nx;
    assign o_normal_y     = r_ny;
    assign o_normal_z     = r_nz;
    assign o_pixel_column = r_ocol;
    assign o_pixel_row    = r_orow;
    assign o_frame_last   = r_olast;

    // A result needs at least one completed row
    a_out_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_rows != 16'd0))
        else $error("result produced before a row was stored");

    // An accepted beat is examined next cycle
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CHECK))
        else $error("accepted beat not examined");

    // Unit magnitudes never exceed one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNIT_WAIT && unit_rsp.done) |-> (unit_rsp.mag <= UNIT_W'(16384)))
        else $error("normal magnitude above one");

    // Normal y always points up
    a_y_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_normal_y[15])
        else $error("negative y component");

endmodule

[bench/tb.sv]
// Self-checking bench for heightmap_normal_generator: directed and random frames.
// Depends on hng_pkg and the block's RTL.
module tb;
    import hng_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic [7:0]         col;
        logic [15:0]        row;
        logic               last;
    } t_normal;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_WIDTH;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = OP_SAMPLE;
    logic [7:0]  i_sample = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [7:0]  o_pixel_column;
    logic [15:0] o_pixel_row;
    logic        o_frame_last;

    heightmap_normal_generator u_dut (.*);

    // Predictor state
    logic [8:0]  cfg_width = 9'd256;
    logic [15:0] cfg_height = 16'd256;
    logic [15:0] cfg_range = 16'd256;
    logic [7:0]  line_a [256];
    logic [7:0]  line_b [256];
    int          col_cnt = 0;
    int          rows_done = 0;
    bit          row_sel = 0;
    bit          flushing = 0;

    t_normal normals_due [$];
    int      mismatches = 0;
    int      normals_seen = 0;
    int      pixels_sent = 0;
    bit      calm = 0;
    int      ready_hold = 0;

    initial forever #10 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    // round(16384*|c|/sqrt(sum)), halves up in magnitude, with the sign of c
    function automatic logic [15:0] unit_q14(longint c, longint sum);
        logic [127:0] target, prod, mag, k;
        int lo, hi, mid;
        mag = (c < 0) ? -c : c;
        target = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            prod = k * k * sum;
            if (prod <= target) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    // Advance the predictor by one accepted beat
    function automatic void predict_normal(logic op, logic [7:0] s);
        int w, h, c, li, ri;
        longint hr, mid, left, right, up, down, x, z, sum;
        t_normal n;
        w = cfg_width;
        h = cfg_height;
        c = col_cnt % 256;
        if (w < 1) w = 1;
        if (w > 256) w = 256;
        if (h < 1) h = 1;
        if ((op == OP_SAMPLE) == flushing) return;
        if (rows_done >= 1) begin
            li = (c > 0) ? c - 1 : 0;
            ri = c + 1;
            if (li > w - 1) li = w - 1;
            if (ri > w - 1) ri = w - 1;
            hr = $signed(cfg_range);
            mid = row_sel ? line_b[c] : line_a[c];
            left = row_sel ? line_b[li] : line_a[li];
            right = row_sel ? line_b[ri] : line_a[ri];
            up = (rows_done >= 2) ? (row_sel ? line_a[c] : line_b[c]) : mid;
            down = flushing ? mid : s;
            x = (left - right) * hr;
            z = (up - down) * hr;
            sum = x * x + z * z + 64'd65280 * 64'd65280;
            n.nx = unit_q14(x, sum);
            n.ny = unit_q14(65280, sum);
            n.nz = unit_q14(z, sum);
            n.col = c[7:0];
            n.row = 16'(rows_done - 1);
            n.last = flushing && (c >= w - 1);
            normals_due.insert(normals_due.size(), n);
        end
        if (!flushing) begin
            if (row_sel) line_a[c] = s;
            else line_b[c] = s;
        end
        if (c >= w - 1) begin
            col_cnt = 0;
            if (flushing) begin
                flushing = 0;
                rows_done = 0;
            end else begin
                rows_done++;
                row_sel = ~row_sel;
                if (rows_done >= h) flushing = 1;
            end
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    task automatic report(string field, int got, int want);
        $display("mismatch %s: got %0d want %0d (normal %0d)", field, got, want, normals_seen);
        mismatches++;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_normal n;
        if (i_rst_n && o_valid && i_ready) begin
            if (normals_due.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                n = normals_due.pop_front();
                if (o_normal_x !== n.nx) report("normal_x", o_normal_x, n.nx);
                if (o_normal_y !== n.ny) report("normal_y", o_normal_y, n.ny);
                if (o_normal_z !== n.nz) report("normal_z", o_normal_z, n.nz);
                if (o_pixel_column !== n.col) report("pixel_column", o_pixel_column, n.col);
                if (o_pixel_row !== n.row) report("pixel_row", o_pixel_row, n.row);
                if (o_frame_last !== n.last) report("frame_last", o_frame_last, n.last);
            end
            normals_seen++;
        end
    end

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Send one beat, holding it until accepted
    task automatic send_beat(logic op, logic [7:0] s);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        predict_normal(op, s);
    endtask

    // Drop valid, drain all expected normals, then let the block settle
    task automatic wait_idle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (normals_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width = data[8:0];
            REG_HEIGHT: cfg_height = data;
            REG_RANGE:  cfg_range = data;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One full frame plus its flush; noise adds beats the block ignores
    task automatic run_frame(int w, int h, bit noise);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (noise && $urandom_range(0, 15) == 0) send_beat(OP_DRAIN, pick_sample());
                send_beat(OP_SAMPLE, pick_sample());
                pixels_sent++;
            end
        end
        for (int c = 0; c < w; c++) begin
            if (noise && $urandom_range(0, 15) == 0) send_beat(OP_SAMPLE, pick_sample());
            send_beat(OP_DRAIN, 8'($urandom));
            pixels_sent++;
        end
        wait_idle();
    endtask

    // Zero registers read as one; a single pixel frame
    task automatic test_degenerate();
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd0);
        send_beat(OP_DRAIN, 8'hA5);
        run_frame(1, 1, 0);
        send_beat(OP_SAMPLE, 8'h00);
        send_beat(OP_DRAIN, 8'h5A);
        wait_idle();
    endtask

    // Range extremes with edge clamps on small frames
    task automatic test_range_extremes();
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_RANGE, 16'h8000);
        run_frame(3, 2, 0);
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_RANGE, 16'h7FFF);
        run_frame(2, 2, 0);
        write_reg(REG_RANGE, 16'h0000);
        run_frame(2, 1, 0);
    endtask

    // Oversized width clamps to the line store depth
    task automatic test_full_width();
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_WIDTH, 16'd300);
        write_reg(REG_RANGE, 16'($urandom));
        run_frame(256, 1, 1);
    endtask

    // Random small frames and settings; the tail runs without random gaps or stalls
    task automatic test_random_frames();
        int w, h;
        while (pixels_sent < 1650) begin
            if (pixels_sent > 1400) calm = 1;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            case ($urandom_range(0, 4))
                0: write_reg(REG_RANGE, 16'h8000);
                1: write_reg(REG_RANGE, 16'h7FFF);
                default: write_reg(REG_RANGE, 16'($urandom));
            endcase
            run_frame(w, h, 1);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_degenerate();
        test_range_extremes();
        test_full_width();
        test_random_frames();
        wait_idle();
        $display("Sent %0d pixel and flush beats over many frame shapes; checked %0d normals.",
                 pixels_sent, normals_seen);
        if (mismatches == 0 && normals_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
